### rtl/dsseg_pkg.sv
// Shared constants and helper functions for the decimal seven-segment frame generator.
`default_nettype none

package dsseg_pkg;

    // Width of the binary input value.
    localparam int VALUE_W = 27;

    // Number of decimal digit positions on the display.
    localparam int DIGITS = 8;

    // Packed BCD word: four bits per digit, position 0 in the lowest nibble.
    localparam int BCD_W = DIGITS * 4;

    // Width of the internal digit position counter.
    localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // Shift-and-add-3 conversion: steps per pipeline stage and number of stages.
    localparam int DD_STEPS  = 4;
    localparam int DD_STAGES = (VALUE_W + DD_STEPS - 1) / DD_STEPS;

    // Binary part of the conversion register, padded with zeros at the top.
    localparam int BIN_W = DD_STAGES * DD_STEPS;

    // Whole conversion register: BCD digits above the binary bits.
    localparam int SH_W = BCD_W + BIN_W;

    // Output field widths.
    localparam int POSITION_W = 3;
    localparam int SELECT_W   = 8;
    localparam int SEGMENTS_W = 8;

    // Largest value that fits in DIGITS decimal digits.
    function automatic longint unsigned max_value();
        longint unsigned p;
        p = 1;
        for (int i = 0; i < DIGITS; i++)
        begin
            p = p * 10;
        end
        return p - 1;
    endfunction

    localparam longint unsigned VALUE_MAX = max_value();

    // Active-low common-anode pattern; the decimal point bit stays high (off).
    function automatic logic [SEGMENTS_W-1:0] seg_decode(input logic [3:0] d);
        logic [SEGMENTS_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'hc0;
            4'd1:    s = 8'hf9;
            4'd2:    s = 8'ha4;
            4'd3:    s = 8'hb0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hf8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = 8'hff;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/decimal_seven_segment_frames.sv
// Top level of the decimal seven-segment frame generator.
//
// The block takes one unsigned number per item on the slave stream and
// emits one display frame per shown decimal digit on the master stream,
// from the most significant shown position down to position 0. Leading
// zeros are blanked, a zero shows a single 0 at position 0, and numbers
// above the display range saturate so that every position shows 9.
// Each frame carries the digit position, a one-hot select byte and an
// active-low segment byte; tlast marks the frame at position 0.
// An accepted number passes a saturation register and seven conversion
// stages (four shift-and-add-3 steps each) before it reaches the frame
// sequencer, which steps past each blanked leading position before it
// offers the first frame of that number.
// The sequencer walks all eight positions, one per cycle unless a shown
// frame stalls, and loads the next number as it leaves position 0. The
// conversion pipeline keeps taking numbers while the sequencer still works on earlier ones.
// When the receiver stalls, the current frame holds, the sequencer stops,
// and the pipeline fills up before s_tready drops; nothing is lost.
// Reset clears all valid bits, so no frame is pending afterwards.
`default_nettype none

module decimal_seven_segment_frames
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [26:0] value, [31:27] zero

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [2:0] digit_position, [10:3] digit_select,
                                        // [18:11] segments, [23:19] zero
    output logic             m_tlast    // last frame of this number
);

    localparam int NS = dsseg_pkg::DD_STAGES;

    // Conversion pipeline: entry 0 holds the saturated value, entries 1..NS
    // hold the partially converted shift register.
    logic [dsseg_pkg::SH_W-1:0] pipe_reg [NS+1];
    logic [NS:0]                vld_reg;
    logic [NS+1:0]              rdy;

    // Frame sequencer.
    logic                         seq_vld_reg;
    logic                         seq_vld_next;
    logic [dsseg_pkg::BCD_W-1:0]  bcd_reg;
    logic [dsseg_pkg::BCD_W-1:0]  bcd_next;
    logic [dsseg_pkg::POS_W-1:0]  pos_reg;
    logic [dsseg_pkg::POS_W-1:0]  pos_next;
    logic                         shown_reg;
    logic                         shown_next;

    logic [dsseg_pkg::VALUE_W-1:0]    in_value;
    logic [dsseg_pkg::VALUE_W-1:0]    sat_value;
    logic [3:0]                       top_digit;
    logic                             cur_show;
    logic                             seq_step;
    logic                             seq_done;
    logic                             seq_load;
    logic [dsseg_pkg::SELECT_W-1:0]   sel;

    // Four shift-and-add-3 steps on the combined BCD and binary register.
    function automatic logic [dsseg_pkg::SH_W-1:0] dd_steps(
        input logic [dsseg_pkg::SH_W-1:0] x
    );
        logic [dsseg_pkg::SH_W-1:0] r;
        logic [3:0]                 nib;
        r = x;
        for (int s = 0; s < dsseg_pkg::DD_STEPS; s++)
        begin
            for (int d = 0; d < dsseg_pkg::DIGITS; d++)
            begin
                nib = r[dsseg_pkg::BIN_W + d*4 +: 4];
                if (nib >= 4'd5)
                begin
                    r[dsseg_pkg::BIN_W + d*4 +: 4] = nib + 4'd3;
                end
            end
            r = r << 1;
        end
        return r;
    endfunction

    // Saturate the incoming number to the largest value the display can show.
    assign in_value  = s_tdata[dsseg_pkg::VALUE_W-1:0];
    assign sat_value = (64'(in_value) > dsseg_pkg::VALUE_MAX)
                       ? dsseg_pkg::VALUE_W'(dsseg_pkg::VALUE_MAX) : in_value;

    // Each stage moves when it is empty or the next stage takes its item.
    always_comb
    begin
        rdy[NS+1] = seq_load;
        for (int k = NS; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k <= NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && s_tvalid)
        begin
            pipe_reg[0] <= dsseg_pkg::SH_W'(sat_value);
        end
        for (int k = 1; k <= NS; k++)
        begin
            if (rdy[k] && vld_reg[k-1])
            begin
                pipe_reg[k] <= dd_steps(pipe_reg[k-1]);
            end
        end
    end

    // The sequencer walks from the top position down. A position is shown
    // once a nonzero digit has been seen, and position 0 is always shown.
    assign top_digit = bcd_reg[dsseg_pkg::BCD_W-1 -: 4];
    assign cur_show  = shown_reg || (top_digit != 4'd0) || (pos_reg == '0);
    assign seq_step  = seq_vld_reg && (!cur_show || m_tready);
    assign seq_done  = seq_step && (pos_reg == '0);
    assign seq_load  = !seq_vld_reg || seq_done;

    always_comb
    begin
        seq_vld_next = seq_vld_reg;
        bcd_next     = bcd_reg;
        pos_next     = pos_reg;
        shown_next   = shown_reg;
        if (seq_load)
        begin
            seq_vld_next = vld_reg[NS];
            bcd_next     = pipe_reg[NS][dsseg_pkg::SH_W-1 -: dsseg_pkg::BCD_W];
            pos_next     = dsseg_pkg::POS_W'(dsseg_pkg::DIGITS - 1);
            shown_next   = 1'b0;
        end
        else if (seq_step)
        begin
            bcd_next   = bcd_reg << 4;
            pos_next   = pos_reg - 1'b1;
            shown_next = cur_show;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_vld_reg <= 1'b0;
        end
        else
        begin
            seq_vld_reg <= seq_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        pos_reg   <= pos_next;
        shown_reg <= shown_next;
    end

    // One-hot select; positions beyond the byte select nothing.
    always_comb
    begin
        for (int i = 0; i < dsseg_pkg::SELECT_W; i++)
        begin
            sel[i] = (32'(pos_reg) == i);
        end
    end

    assign m_tvalid = seq_vld_reg && cur_show;
    assign m_tlast  = (pos_reg == '0);
    assign m_tdata  = {5'b0,
                       dsseg_pkg::seg_decode(top_digit),
                       sel,
                       dsseg_pkg::POSITION_W'(pos_reg)};

endmodule

`default_nettype wire
